>>> design/lts_pkg.sv
// Shared types and constants for the lexical token scanner.
`timescale 1ns / 1ps
package lts_pkg;

  localparam int unsigned KindW   = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned NumKw   = 17;

  // Token kind codes.
  localparam logic [KindW-1:0] KindLParen  = 6'd0;
  localparam logic [KindW-1:0] KindDot     = 6'd5;
  localparam logic [KindW-1:0] KindSlash   = 6'd12;
  localparam logic [KindW-1:0] KindBang    = 6'd13;
  localparam logic [KindW-1:0] KindEqual   = 6'd15;
  localparam logic [KindW-1:0] KindLess    = 6'd17;
  localparam logic [KindW-1:0] KindGreater = 6'd19;
  localparam logic [KindW-1:0] KindComment = 6'd21;
  localparam logic [KindW-1:0] KindString  = 6'd22;
  localparam logic [KindW-1:0] KindNumber  = 6'd23;
  localparam logic [KindW-1:0] KindIdent   = 6'd24;
  localparam logic [KindW-1:0] KindKw0     = 6'd25;
  localparam logic [KindW-1:0] KindEof     = 6'd42;

  // Status codes.
  localparam logic [StatusW-1:0] StatOk         = 2'd0;
  localparam logic [StatusW-1:0] StatUnexpected = 2'd1;
  localparam logic [StatusW-1:0] StatUnterm     = 2'd2;

  // Characters the scanner tests for.
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;

  // Scanner modes.
  typedef enum logic [3:0] {
    ModeIdle, ModeOp, ModeSlash, ModeComment, ModeString,
    ModeInt, ModeDot, ModeFrac, ModeIdent
  } mode_e;

  // Keyword table: up to 6 characters, first character in the low byte.
  localparam logic [47:0] KwText [NumKw] = '{
    48'h000000726176, 48'h0000006E7566, 48'h0073_73616C63, 48'h0072_65707573,
    48'h000073696874, 48'h000000006669, 48'h0000_65736C65, 48'h0065_6C696877,
    48'h000000726F66, 48'h00000000726F, 48'h000000646E61, 48'h747265737361,
    48'h0074_6E697270, 48'h6E7275746572, 48'h0000006C696E, 48'h0000_65757274,
    48'h0065_736C6166
  };
  localparam logic [2:0] KwLen [NumKw] = '{
    3'd3, 3'd3, 3'd5, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3, 3'd6,
    3'd5, 3'd6, 3'd3, 3'd4, 3'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == ChUnder);
  endfunction

  // One- or two-character operator kind.
  function automatic logic [KindW-1:0] op_kind(input logic [7:0] op, input logic two);
    logic [KindW-1:0] base;
    case (op)
      8'h21:   base = KindBang;
      ChEq:    base = KindEqual;
      8'h3C:   base = KindLess;
      default: base = KindGreater;
    endcase
    return base + {5'd0, two};
  endfunction

  // Punctuation index 0..11, or 12 when the byte is not punctuation.
  function automatic logic [3:0] punct_idx(input logic [7:0] c);
    case (c)
      8'h28: return 4'd0;
      8'h29: return 4'd1;
      8'h7B: return 4'd2;
      8'h7D: return 4'd3;
      8'h2C: return 4'd4;
      8'h2E: return 4'd5;
      8'h2D: return 4'd6;
      8'h2B: return 4'd7;
      8'h2A: return 4'd8;
      8'h3B: return 4'd9;
      8'h3A: return 4'd10;
      8'h3F: return 4'd11;
      default: return 4'd12;
    endcase
  endfunction

endpackage

>>> design/lts_out_fifo.sv
// Small output queue that holds tokens until the receiver takes them.
`timescale 1ns / 1ps
module lts_out_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic [$clog2(Depth+1)-1:0] free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign free_o      = CW'(Depth) - cnt_q;

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end
endmodule

>>> design/lexical_token_scanner_top.sv
// Top level of the lexical token scanner: byte scanner and token queue.
// Usage:
//   Input channel (valid_i/ready_o): one transaction carries kind_i and
//   byte_value_i, a source byte or an end-of-input marker.
//   Output channel (valid_o/ready_i): one transaction carries one token with
//   kind, offset, length, line, status and a last flag for the final token
//   caused by one input transaction.
//   An input is scanned in the cycle it is accepted. Its first token is
//   written to the six-entry output queue in the next cycle, from the
//   result register, and can be taken once the queue has stored it.
//   Throughput is one byte per cycle while ready_o is high. An input that
//   yields two or three tokens holds ready_o low while they enter the queue.
//   Otherwise an input is taken while at least three entries stay free after
//   the token being written, which a receiver that takes one token per cycle
//   always leaves. When the receiver stalls, tokens collect and ready_o drops.
//   End of input flushes the pending token, emits end-of-file and returns
//   the scanner to its reset state for a new text.
//   Reset (rst_ni low) clears the scanner state, line to one, offsets to
//   zero, and empties the queue.
`timescale 1ns / 1ps
module lexical_token_scanner_top #(
  parameter int unsigned KEYWORD_MAX_LEN = 6,
  parameter int unsigned OFFSET_BITS     = 32,
  parameter int unsigned LINE_BITS       = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [5:0]  token_kind_o,
  output logic [31:0] token_offset_o,
  output logic [31:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import lts_pkg::*;

  localparam int unsigned LenW  = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int unsigned TokW  = KindW + 32 + 32 + 24 + StatusW + 1;
  localparam int unsigned Depth = 6;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam logic [OFFSET_BITS-1:0] OffMax  = '1;
  localparam logic [LINE_BITS-1:0]   LineMax = '1;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [StatusW-1:0]     status;
  } tok_t;

  // Scanner state.
  mode_e                  mode_q, mode_d;
  logic [7:0]             op_q, op_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [7:0]             kwbuf_q [KEYWORD_MAX_LEN];
  logic [LenW-1:0]        idlen_q, idlen_d;
  logic                   kw_wr;

  // Registered results of the scan.
  tok_t                   res_q [3];
  logic [1:0]             nres_q;
  logic [LINE_BITS-1:0]   rline_q;

  tok_t                   res_d [3];
  logic [1:0]             nres_d;

  logic                   accept;
  logic [CW-1:0]          free;
  logic [7:0]             c;
  logic                   push;

  assign accept  = valid_i && ready_o;
  assign ready_o = free >= (CW'(3) + CW'(push));
  assign c       = byte_value_i;

  function automatic logic [OFFSET_BITS-1:0] sub_floor(
      input logic [OFFSET_BITS-1:0] a, input logic [OFFSET_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Line numbers wider than the output port saturate.
  function automatic logic [23:0] sat_line(input logic [LINE_BITS-1:0] v);
    return (LINE_BITS > 24 && (v >> 24) != '0) ? '1 : 24'(v);
  endfunction

  // Keyword match over the identifier buffer.
  logic [KindW-1:0] ident_k;
  always_comb begin
    logic hit;
    ident_k = KindIdent;
    for (int i = NumKw - 1; i >= 0; i--) begin
      hit = (idlen_q == LenW'(KwLen[i]));
      for (int j = 0; j < 6; j++) begin
        if (j < int'(KwLen[i]) && kwbuf_q[j] != KwText[i][8*j +: 8]) hit = 1'b0;
      end
      if (hit) ident_k = KindKw0 + KindW'(i);
    end
  end

  // Single-pass scan of one input.
  always_comb begin
    logic [OFFSET_BITS-1:0] p, st1;
    logic taken, at_end, flushing;
    logic [3:0] pi;
    p      = pos_q;
    // A string body starts after the quote; the offset saturates.
    st1    = (start_q == OffMax) ? OffMax : start_q + 1'b1;
    mode_d = mode_q;
    op_d   = op_q;
    pos_d  = pos_q;
    start_d = start_q;
    line_d = line_q;
    idlen_d = idlen_q;
    kw_wr  = 1'b0;
    nres_d = 2'd0;
    taken  = 1'b0;
    flushing = 1'b0;
    at_end = kind_i;
    pi     = punct_idx(c);
    for (int k = 0; k < 3; k++) res_d[k] = '0;

    if (at_end) begin
      flushing = 1'b1;
    end else begin
      case (mode_q)
        ModeOp: begin
          if (c == ChEq) begin
            res_d[0] = '{op_kind(op_q, 1'b1), start_q, OFFSET_BITS'(2), StatOk};
            nres_d = 2'd1;
            mode_d = ModeIdle;
            taken = 1'b1;
          end
        end
        ModeSlash: if (c == ChSlash) begin mode_d = ModeComment; taken = 1'b1; end
        ModeComment: if (c != ChNl) taken = 1'b1;
        ModeString: begin
          taken = 1'b1;
          if (c == ChQuote) begin
            res_d[0] = '{KindString, st1, sub_floor(p, st1), StatOk};
            nres_d = 2'd1;
            mode_d = ModeIdle;
          end else if (c == ChNl && line_q != LineMax) begin
            line_d = line_q + 1'b1;
          end
        end
        ModeInt: begin
          if (is_digit(c)) taken = 1'b1;
          else if (c == ChDot) begin mode_d = ModeDot; taken = 1'b1; end
        end
        ModeDot: if (is_digit(c)) begin mode_d = ModeFrac; taken = 1'b1; end
        ModeFrac: if (is_digit(c)) taken = 1'b1;
        ModeIdent: begin
          if (is_alpha(c) || is_digit(c)) begin
            taken = 1'b1;
            kw_wr = idlen_q < LenW'(KEYWORD_MAX_LEN);
            if (idlen_q <= LenW'(KEYWORD_MAX_LEN)) idlen_d = idlen_q + 1'b1;
          end
        end
        default: taken = 1'b1;
      endcase
      if (mode_q == ModeIdle) taken = 1'b0;
      flushing = !taken && mode_q != ModeIdle;
    end

    // Pending token flush.
    if (flushing) begin
      mode_d = ModeIdle;
      case (mode_q)
        ModeOp: begin
          res_d[0] = '{op_kind(op_q, 1'b0), start_q, OFFSET_BITS'(1), StatOk};
          nres_d = 2'd1;
        end
        ModeSlash: begin
          res_d[0] = '{KindSlash, start_q, OFFSET_BITS'(1), StatOk};
          nres_d = 2'd1;
        end
        ModeComment: begin
          res_d[0] = '{KindComment, start_q, sub_floor(p, start_q), StatOk};
          nres_d = 2'd1;
        end
        ModeString: begin
          res_d[0] = '{KindString, st1, sub_floor(p, st1), at_end ? StatUnterm : StatOk};
          nres_d = 2'd1;
        end
        ModeInt, ModeFrac: begin
          res_d[0] = '{KindNumber, start_q, sub_floor(p, start_q), StatOk};
          nres_d = 2'd1;
        end
        ModeDot: begin
          res_d[0] = '{KindNumber, start_q, sub_floor(sub_floor(p, OFFSET_BITS'(1)), start_q),
                       StatOk};
          res_d[1] = '{KindDot, sub_floor(p, OFFSET_BITS'(1)), OFFSET_BITS'(1), StatOk};
          nres_d = 2'd2;
        end
        ModeIdent: begin
          res_d[0] = '{(idlen_q > LenW'(KEYWORD_MAX_LEN)) ? KindIdent : ident_k,
                       start_q, sub_floor(p, start_q), StatOk};
          nres_d = 2'd1;
        end
        default: ;
      endcase
    end

    if (at_end) begin
      res_d[nres_d] = '{KindEof, p, '0, StatOk};
      nres_d = nres_d + 2'd1;
    end else if (!taken) begin
      // Scan the byte from idle.
      start_d = p;
      if (pi != 4'd12) begin
        res_d[nres_d] = '{KindW'(pi), p, OFFSET_BITS'(1), StatOk};
        nres_d = nres_d + 2'd1;
      end else if (c == 8'h21 || c == ChEq || c == 8'h3C || c == 8'h3E) begin
        op_d = c;
        mode_d = ModeOp;
      end else if (c == ChSlash) begin
        mode_d = ModeSlash;
      end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
      end else if (c == ChNl) begin
        if (line_q != LineMax) line_d = line_q + 1'b1;
      end else if (c == ChQuote) begin
        mode_d = ModeString;
      end else if (is_digit(c)) begin
        mode_d = ModeInt;
      end else if (is_alpha(c)) begin
        idlen_d = LenW'(1);
        mode_d = ModeIdent;
      end else begin
        res_d[nres_d] = '{KindLParen, p, OFFSET_BITS'(1), StatUnexpected};
        nres_d = nres_d + 2'd1;
      end
    end
    if (!at_end && pos_q != OffMax) pos_d = pos_q + 1'b1;
  end

  // Identifier buffer writes.
  always_ff @(posedge clk_i) begin
    if (accept && !kind_i) begin
      if (mode_q == ModeIdent && kw_wr) begin
        kwbuf_q[idlen_q[$clog2(KEYWORD_MAX_LEN)-1:0]] <= c;
      end else if (mode_d == ModeIdent && mode_q != ModeIdent) begin
        kwbuf_q[0] <= c;
      end
    end
  end

  // Result register payload. Every token of one scan carries the line
  // before any newline in that byte is counted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q   <= res_d;
      rline_q <= line_q;
    end
  end

  // Scanner control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      op_q    <= '0;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= LINE_BITS'(1);
      idlen_q <= '0;
      nres_q  <= '0;
    end else begin
      nres_q <= accept ? nres_d : 2'd0;
      if (accept) begin
        if (kind_i) begin
          mode_q  <= ModeIdle;
          op_q    <= '0;
          pos_q   <= '0;
          start_q <= '0;
          line_q  <= LINE_BITS'(1);
          idlen_q <= '0;
        end else begin
          mode_q  <= mode_d;
          op_q    <= op_d;
          pos_q   <= pos_d;
          start_q <= start_d;
          line_q  <= line_d;
          idlen_q <= idlen_d;
        end
      end
    end
  end

  // Serialize up to three registered results into the queue, one per
  // cycle through its single write port.
  logic [1:0] drain_q;
  logic [1:0] drain_cnt_q;
  tok_t       hold_q [3];
  logic [LINE_BITS-1:0] hline_q;
  logic [1:0] total;
  logic [TokW-1:0] pdata;

  // Results of one scan are pushed one per cycle: the first from the result register, the rest from a holding copy.
  assign total = (drain_cnt_q != 2'd0) ? drain_cnt_q : nres_q;
  assign push  = total != 2'd0;
  always_comb begin
    tok_t t;
    logic [31:0] o32, l32;
    logic [23:0] ln;
    logic        lst;
    if (drain_cnt_q != 2'd0) begin
      t = hold_q[drain_q];
      ln = sat_line(hline_q);
      lst = (drain_q + 2'd1) == drain_cnt_q;
    end else begin
      t = res_q[0];
      ln = sat_line(rline_q);
      lst = nres_q == 2'd1;
    end
    o32 = (OFFSET_BITS > 32 && (t.off >> 32) != '0) ? '1 : 32'(t.off);
    l32 = (OFFSET_BITS > 32 && (t.len >> 32) != '0) ? '1 : 32'(t.len);
    pdata = {t.kind, o32, l32, ln, t.status, lst};
  end

  always_ff @(posedge clk_i) begin
    if (nres_q > 2'd1 && drain_cnt_q == 2'd0) begin
      hold_q  <= res_q;
      hline_q <= rline_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= '0;
      drain_cnt_q <= '0;
    end else if (drain_cnt_q != 2'd0) begin
      if (drain_q + 2'd1 == drain_cnt_q) begin
        drain_cnt_q <= '0;
        drain_q     <= '0;
      end else begin
        drain_q <= drain_q + 2'd1;
      end
    end else if (nres_q > 2'd1) begin
      drain_cnt_q <= nres_q;
      drain_q     <= 2'd1;
    end
  end

  // A new scan result lands while a burst drains only if room is reserved:
  // stall input while a burst drains.
  logic [CW-1:0] fifo_free;
  assign free = (drain_cnt_q != 2'd0 || nres_q > 2'd1) ? '0 : fifo_free;

  lts_out_fifo #(.Width(TokW), .Depth(Depth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (pdata),
    .free_o      (fifo_free),
    .out_valid_o (valid_o),
    .out_ready_i (ready_i),
    .out_data_o  ({token_kind_o, token_offset_o, token_length_o, line_number_o,
                   status_o, last_o})
  );
endmodule
